// ----- design/mera_pkg.sv -----
package mera_pkg;

  localparam int unsigned BaseW = 22;

  localparam logic [7:0] RELOC_WORD32 = 8'd2;
  localparam logic [7:0] RELOC_JUMP26 = 8'd4;
  localparam logic [7:0] RELOC_HI16   = 8'd5;
  localparam logic [7:0] RELOC_LO16   = 8'd6;

  localparam logic [31:0] Mask26   = 32'h03ff_ffff;
  localparam logic [31:0] MaskOp   = 32'hfc00_0000;
  localparam logic [BaseW-1:0] BaseReset = 22'h02_3f00;

  typedef enum logic {
    KIND_PLAIN = 1'b0,
    KIND_LO16  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] word;
    logic [31:0] hi_addr;
    logic [31:0] hi_word;
  } entry_t;

  function automatic logic [BaseW-1:0] eff_base(input logic [20:0] raw);
    logic [BaseW-1:0] b;
    b = {1'b0, raw};
    if (raw[1:0] != 2'b00) begin
      b = {(b[BaseW-1:2] + (BaseW-2)'(1)), 2'b00};
    end
    return b;
  endfunction

endpackage

// ----- design/mera_front.sv -----
module mera_front
  import mera_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BaseW-1:0] base_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      record_offset_i,
  input  logic [7:0]       reloc_type_i,
  input  logic [31:0]      current_word_i,
  input  logic             q_full_i,
  output logic             push_o,
  output entry_t           push_data_o
);

  logic [31:0] pend_off_q, pend_off_d;
  logic [31:0] pend_word_q, pend_word_d;
  logic [31:0] base32;
  logic [31:0] jump_low;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign base32     = 32'(base_i);
  assign jump_low   = (current_word_i & Mask26) + (base32 >> 2);

  always_comb begin
    pend_off_d          = pend_off_q;
    pend_word_d         = pend_word_q;
    push_data_o.kind    = KIND_PLAIN;
    push_data_o.addr    = base32 + record_offset_i;
    push_data_o.word    = current_word_i;
    push_data_o.hi_addr = base32 + pend_off_q;
    push_data_o.hi_word = pend_word_q;
    unique case (reloc_type_i)
      RELOC_WORD32: push_data_o.word = current_word_i + base32;
      RELOC_JUMP26: push_data_o.word = (current_word_i & MaskOp) | jump_low;
      RELOC_HI16: begin
        if (push_o) begin
          pend_off_d  = record_offset_i;
          pend_word_d = current_word_i;
        end
      end
      RELOC_LO16: push_data_o.kind = KIND_LO16;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_off_q  <= '0;
      pend_word_q <= '0;
    end else begin
      pend_off_q  <= pend_off_d;
      pend_word_q <= pend_word_d;
    end
  end

endmodule

// ----- design/mera_queue.sv -----
module mera_queue
  import mera_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output entry_t head_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- design/mera_back.sv -----
module mera_back
  import mera_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BaseW-1:0] base_i,
  input  logic             head_valid_i,
  input  entry_t           head_data_i,
  output logic             pop_o,
  output logic             phase_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      write_address_o,
  output logic [31:0]      write_word_o,
  output logic             last_write_o
);

  logic        out_valid_q;
  logic        phase_q;
  logic [31:0] addr_q, addr_d;
  logic [31:0] word_q, word_d;
  logic        last_q, last_d;
  logic        load;
  logic        hi_step;
  logic [31:0] lo_sext;
  logic [31:0] h;
  logic [15:0] hi_half;
  logic [15:0] lo_half;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign hi_step = (head_data_i.kind == KIND_LO16) && !phase_q;
  assign pop_o   = load && !hi_step;
  assign phase_o = phase_q;

  // carry-adjusted high half for the paired hi16 word
  assign lo_sext = {{16{head_data_i.word[15]}}, head_data_i.word[15:0]};
  assign h       = {head_data_i.hi_word[15:0], 16'h0000} + lo_sext + 32'(base_i);
  assign hi_half = h[31:16] + 16'(h[15]);
  assign lo_half = base_i[15:0] + head_data_i.word[15:0];

  always_comb begin
    if (hi_step) begin
      addr_d = head_data_i.hi_addr;
      word_d = {head_data_i.hi_word[31:16], hi_half};
      last_d = 1'b0;
    end else if (head_data_i.kind == KIND_LO16) begin
      addr_d = head_data_i.addr;
      word_d = {head_data_i.word[31:16], lo_half};
      last_d = 1'b1;
    end else begin
      addr_d = head_data_i.addr;
      word_d = head_data_i.word;
      last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q     <= hi_step;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q <= addr_d;
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = addr_q;
  assign write_word_o    = word_q;
  assign last_write_o    = last_q;

endmodule

// ----- design/mips_elf_relocation_applier.sv -----
// Applies MIPS REL relocation records against the load base held in the one
// configuration register (rounded up to a multiple of four on write). An item
// is accepted every cycle while the record queue has room; records of the other
// types give one write each, a LO16 record gives two (the paired HI16 word,
// then its own word). Results leave through a registered output stage that
// loads from the head of the record queue.
module mips_elf_relocation_applier
  import mera_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [20:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] record_offset_i,
  input  logic [7:0]  reloc_type_i,
  input  logic [31:0] current_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] write_address_o,
  output logic [31:0] write_word_o,
  output logic        last_write_o
);

  logic [BaseW-1:0] base_q;
  logic             push;
  entry_t           push_data;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  entry_t           head_data;
  logic             phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (cfg_we_i) begin
      base_q <= eff_base(cfg_data_i);
    end
  end

  mera_front u_front (
    .clk_i,
    .rst_ni,
    .base_i      (base_q),
    .in_valid_i,
    .in_ready_o,
    .record_offset_i,
    .reloc_type_i,
    .current_word_i,
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mera_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  mera_back u_back (
    .clk_i,
    .rst_ni,
    .base_i       (base_q),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .phase_o      (phase),
    .out_valid_o,
    .out_ready_i,
    .write_address_o,
    .write_word_o,
    .last_write_o
  );

  a_phase_on_lo16 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase |-> (head_valid && head_data.kind == KIND_LO16))
    else $error("second step pending without lo16 record at queue head");

  a_hi_then_lo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_write_o) |=> (out_valid_o && last_write_o))
    else $error("hi16 write not followed by lo16 write");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (in_ready_o && !q_full))
    else $error("queue pushed while full");

endmodule

// ----- bench/mera_checker.sv -----
`timescale 1ns / 100ps
module mera_checker
  import mera_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [20:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] record_offset_i,
  input  logic [7:0]  reloc_type_i,
  input  logic [31:0] current_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] write_address_i,
  input  logic [31:0] write_word_i,
  input  logic        last_write_i,
  output int unsigned mismatch_count_o,
  output int unsigned writes_outstanding_o,
  output int unsigned writes_checked_o
);

  localparam logic [20:0] LoadBaseReset = 21'h02_3f00;
  localparam logic [31:0] HalfMask      = 32'h0000_ffff;
  localparam int unsigned ReportLimit   = 10;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] word;
    logic        last;
  } mem_write_t;

  logic [20:0] load_base;
  logic [31:0] hi16_offset;
  logic [31:0] hi16_word;
  mem_write_t  expected_writes[$];
  int unsigned mismatches;
  int unsigned checked;

  function automatic logic [31:0] rounded_base(input logic [20:0] raw);
    logic [31:0] b;
    b = {11'd0, raw};
    if (b[1:0] != 2'b00) begin
      b = {b[31:2], 2'b00} + 32'd4;
    end
    return b;
  endfunction

  // works out the writes one record causes and queues them in order
  task automatic relocate_record(input logic [31:0] offset, input logic [7:0] rtype,
                                 input logic [31:0] word);
    logic [31:0] base;
    logic [31:0] lo;
    logic [31:0] h;
    logic [31:0] hi_half;
    logic [31:0] lo_sum;
    mem_write_t  w;
    base   = rounded_base(load_base);
    w.addr = base + offset;
    w.word = word;
    w.last = 1'b1;
    case (rtype)
      RELOC_WORD32: w.word = word + base;
      RELOC_JUMP26: w.word = (word & MaskOp) | ((word & Mask26) + (base >> 2));
      RELOC_HI16: begin
        hi16_offset = offset;
        hi16_word   = word;
      end
      RELOC_LO16: begin
        mem_write_t hw;
        lo      = {{16{word[15]}}, word[15:0]};
        h       = {hi16_word[15:0], 16'h0000} + lo + base;
        hi_half = ((h >> 16) + {31'd0, h[15]}) & HalfMask;
        hw.addr = base + hi16_offset;
        hw.word = {hi16_word[31:16], hi_half[15:0]};
        hw.last = 1'b0;
        expected_writes = {expected_writes, hw};
        lo_sum  = base + lo;
        w.word  = {word[31:16], lo_sum[15:0]};
      end
      default: ;
    endcase
    expected_writes = {expected_writes, w};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_base   = LoadBaseReset;
      hi16_offset = '0;
      hi16_word   = '0;
      expected_writes.delete();
      mismatches  = 0;
      checked     = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        relocate_record(record_offset_i, reloc_type_i, current_word_i);
      end
      if (cfg_we_i) begin
        load_base = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: unexpected write addr %h word %h last %b", $realtime,
                     write_address_i, write_word_i, last_write_i);
          end
        end else begin
          mem_write_t exp;
          exp = expected_writes.pop_front();
          if (exp.addr !== write_address_i || exp.word !== write_word_i ||
              exp.last !== last_write_i) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t: write mismatch: expected addr %h word %h last %b, got %h %h %b",
                       $realtime, exp.addr, exp.word, exp.last,
                       write_address_i, write_word_i, last_write_i);
            end
          end
        end
      end
    end
    mismatch_count_o     <= mismatches;
    writes_outstanding_o <= expected_writes.size();
    writes_checked_o     <= checked;
  end

endmodule

// ----- bench/tb_mips_elf_relocation_applier.sv -----
`timescale 1ns / 100ps
module tb_mips_elf_relocation_applier
  import mera_pkg::*;
();

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems   = 150;
  localparam logic [7:0]  RelocNone    = 8'd0;
  localparam logic [7:0]  RelocTypeMax = 8'hff;
  localparam logic [20:0] BaseMax      = 21'h1f_ffff;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [20:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] record_offset_i;
  logic [7:0]  reloc_type_i;
  logic [31:0] current_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] write_address_o;
  logic [31:0] write_word_o;
  logic        last_write_o;

  int unsigned mismatch_count;
  int unsigned writes_outstanding;
  int unsigned writes_checked;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned records_sent;
  int unsigned base_settings;
  int unsigned cycle_count;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  mips_elf_relocation_applier DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .record_offset_i (record_offset_i),
    .reloc_type_i    (reloc_type_i),
    .current_word_i  (current_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_address_o (write_address_o),
    .write_word_o    (write_word_o),
    .last_write_o    (last_write_o)
  );

  mera_checker u_mera_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .record_offset_i      (record_offset_i),
    .reloc_type_i         (reloc_type_i),
    .current_word_i       (current_word_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .write_address_i      (write_address_o),
    .write_word_i         (write_word_o),
    .last_write_i         (last_write_o),
    .mismatch_count_o     (mismatch_count),
    .writes_outstanding_o (writes_outstanding),
    .writes_checked_o     (writes_checked)
  );

  always @(posedge clk_i) begin
    if (recv_stall_pct == 0) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d writes still expected", cycle_count,
               writes_outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid stays high after acceptance; an idle gap before the next item or a drain lowers it
  task automatic send_record(input logic [31:0] offset, input logic [7:0] rtype,
                             input logic [31:0] word);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    record_offset_i <= offset;
    reloc_type_i    <= rtype;
    current_word_i  <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    records_sent++;
  endtask

  task automatic drain_writes();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (writes_outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [20:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    base_settings++;
  endtask

  function automatic logic [31:0] random_offset();
    if ($urandom_range(3) == 0) begin
      return $urandom();
    end
    return {16'h0000, 16'($urandom_range(16'hffff)) & 16'hfffc};
  endfunction

  // a hi16 followed by one to three lo16 in a quarter of picks, else single records and noise
  task automatic send_random_burst();
    int unsigned pick;
    int unsigned lo_count;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_record(random_offset(), RELOC_HI16, $urandom());
      lo_count = $urandom_range(3, 1);
      repeat (lo_count) send_record(random_offset(), RELOC_LO16, $urandom());
    end else if (pick < 40) begin
      send_record(random_offset(), RELOC_WORD32, $urandom());
    end else if (pick < 55) begin
      send_record(random_offset(), RELOC_JUMP26, $urandom());
    end else if (pick < 63) begin
      send_record(random_offset(), RELOC_HI16, $urandom());
    end else if (pick < 75) begin
      send_record(random_offset(), RELOC_LO16, $urandom());
    end else begin
      send_record(random_offset(), 8'($urandom_range(255)), $urandom());
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned target;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    record_offset_i = '0;
    reloc_type_i    = RelocNone;
    current_word_i  = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    records_sent    = 0;
    base_settings   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset base, lo16 before any hi16, wrapping addresses, jump carry
    send_record(32'h0000_0040, RELOC_LO16, 32'h2421_8000);
    send_record(32'hffff_fffc, RELOC_WORD32, 32'hffff_ffff);
    send_record(32'hffff_ffff, RELOC_WORD32, 32'h0000_0000);
    send_record(32'h0000_0000, RELOC_JUMP26, 32'hffff_ffff);
    send_record(32'h0000_0004, RELOC_JUMP26, 32'h0000_0000);
    // one hi16 shared by several lo16
    send_record(32'h0000_0100, RELOC_HI16, 32'h3c01_7fff);
    send_record(32'h0000_0104, RELOC_LO16, 32'h2421_8000);
    send_record(32'h0000_0108, RELOC_LO16, 32'h2421_7fff);
    send_record(32'h0000_010c, RELOC_LO16, 32'hffff_ffff);
    // types that pass the word through, then a hi16 with its lo16
    send_record(32'h0000_0008, RelocNone, 32'hdead_beef);
    send_record(32'h0000_000c, RelocTypeMax, 32'h0123_4567);
    send_record(32'hffff_fffc, RELOC_HI16, 32'hffff_ffff);
    send_record(32'h0000_0010, RELOC_LO16, 32'hffff_ffff);
    drain_writes();

    // largest base, unaligned so it rounds up past 21 bits
    write_base(BaseMax);
    send_record(32'hffff_ffff, RELOC_WORD32, 32'hffff_ffff);
    send_record(32'h0000_0020, RELOC_JUMP26, 32'h03ff_ffff);
    send_record(32'h0000_0024, RELOC_HI16, 32'h0000_ffff);
    send_record(32'h0000_0028, RELOC_LO16, 32'h0000_7fff);
    drain_writes();

    write_base('0);
    send_record(32'h0000_0030, RELOC_WORD32, 32'h8000_0000);
    send_record(32'h0000_0034, RELOC_JUMP26, 32'hffff_ffff);
    send_record(32'h0000_0038, RELOC_LO16, 32'h0000_8000);

    for (phase = 0; phase < 4; phase++) begin
      drain_writes();
      case (phase)
        0: begin
          write_base(21'($urandom_range(BaseMax)));
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_base(BaseMax);
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          write_base(21'h00_0002);
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          write_base(21'($urandom_range(BaseMax)));
          send_idle_pct  = 37;
          recv_stall_pct = 37;
        end
      endcase
      target = records_sent + PhaseItems;
      while (records_sent < target) send_random_burst();
    end
    drain_writes();

    $display("sent %0d records under %0d load base settings and four handshake mixes",
             records_sent, base_settings);
    $display("checked %0d writes, %0d mismatches", writes_checked, mismatch_count);
    if (mismatch_count == 0 && writes_outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
